FILE: hw/rtl/priority_command_mux_with_timeout_top_defines.svh
// Assertion macros for the priority command multiplexer.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef PRIORITY_COMMAND_MUX_WITH_TIMEOUT_TOP_DEFINES_SVH
`define PRIORITY_COMMAND_MUX_WITH_TIMEOUT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CMX_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CMX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: hw/rtl/cmx_pkg.sv
// Shared types and constants of the priority command multiplexer.
// Used by the interfaces, cmx_core, the top level and the testbench; depends on nothing.
package cmx_pkg;

  // Default parameter values and fixed field widths.
  localparam int unsigned NumSourcesDef    = 4;
  localparam int unsigned TimeoutBitsDef   = 12;
  localparam int unsigned WordBits         = 32;
  localparam int unsigned NumWords         = 6;
  localparam int unsigned SrcBits          = 2;
  localparam int unsigned ModeBits         = 4;
  localparam int unsigned PrioBits         = 8;
  localparam int unsigned ReqTypeBits      = 2;
  localparam int unsigned CfgIdxBits       = 2;
  localparam int unsigned CfgDataBits      = 48;
  localparam int unsigned PrioTableBits    = 32;
  localparam int unsigned ModeTableBits    = 16;
  localparam int unsigned EmergBits        = 4;
  localparam int unsigned TimeoutTableBits = 48;

  // Request type codes; the fourth code is unused and ignored.
  typedef enum logic [ReqTypeBits-1:0] {
    REQ_CMD  = 2'd0,
    REQ_MODE = 2'd1,
    REQ_TICK = 2'd2
  } req_type_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_PRIO    = 2'd0,
    CFG_MODE    = 2'd1,
    CFG_EMERG   = 2'd2,
    CFG_TIMEOUT = 2'd3
  } cfg_idx_e;

  typedef logic [WordBits-1:0] word_t;

  // One request: element 0 is linear x, up to element 5 which is angular z.
  typedef struct packed {
    logic [ReqTypeBits-1:0]  req_type;
    logic [SrcBits-1:0]      source_index;
    logic [ModeBits-1:0]     new_key_mode;
    word_t [NumWords-1:0]    twist;
  } cmx_req_t;

  // One result, with the twist words in the same order as the request.
  typedef struct packed {
    word_t [NumWords-1:0]    twist;
    logic [SrcBits-1:0]      source;
    logic                    stop;
  } cmx_res_t;

  // Ownership status reported by the decision logic.
  typedef struct packed {
    logic owner_valid;
    logic timer_running;
  } cmx_status_t;

endpackage

FILE: hw/rtl/cmx_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on cmx_pkg for the field widths.
interface cmx_cmd_if
  import cmx_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [ReqTypeBits-1:0] req_type;
  logic [SrcBits-1:0]     source_index;
  logic [ModeBits-1:0]    new_key_mode;
  logic [WordBits-1:0]    linear_x;
  logic [WordBits-1:0]    linear_y;
  logic [WordBits-1:0]    linear_z;
  logic [WordBits-1:0]    angular_x;
  logic [WordBits-1:0]    angular_y;
  logic [WordBits-1:0]    angular_z;

  modport source (
    output valid, req_type, source_index, new_key_mode,
    output linear_x, linear_y, linear_z, angular_x, angular_y, angular_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, source_index, new_key_mode,
    input  linear_x, linear_y, linear_z, angular_x, angular_y, angular_z,
    output ready
  );
endinterface

interface cmx_res_if
  import cmx_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [WordBits-1:0] out_linear_x;
  logic [WordBits-1:0] out_linear_y;
  logic [WordBits-1:0] out_linear_z;
  logic [WordBits-1:0] out_angular_x;
  logic [WordBits-1:0] out_angular_y;
  logic [WordBits-1:0] out_angular_z;
  logic [SrcBits-1:0]  out_source;
  logic                stop_flag;

  modport source (
    output valid, out_linear_x, out_linear_y, out_linear_z,
    output out_angular_x, out_angular_y, out_angular_z, out_source, stop_flag,
    input  ready
  );
  modport sink (
    input  valid, out_linear_x, out_linear_y, out_linear_z,
    input  out_angular_x, out_angular_y, out_angular_z, out_source, stop_flag,
    output ready
  );
endinterface

FILE: hw/rtl/cmx_pipe_reg.sv
// Pipeline register stage with valid/ready flow control.
// Generic over the payload width; depends on nothing else.
module cmx_pipe_reg #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [Width-1:0] data_i,
  output logic             ready_o,
  output logic             valid_o,
  output logic [Width-1:0] data_o,
  input  logic             ready_i
);

  logic             valid_q;
  logic [Width-1:0] data_q;

  // The stage takes a new request when empty or when its content leaves.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload needs no reset; it is only looked at while valid.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/cmx_core.sv
// Configuration registers, ownership state and the per-request decision.
// Depends on cmx_pkg for request, result and status types.
module cmx_core
  import cmx_pkg::*;
#(
  parameter int unsigned NumSources  = NumSourcesDef,
  parameter int unsigned TimeoutBits = TimeoutBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  input  logic                   req_valid_i,
  input  cmx_req_t               req_i,
  output logic                   req_ready_o,
  output logic                   res_valid_o,
  output cmx_res_t               res_o,
  input  logic                   res_ready_i,
  output cmx_status_t            status_o
);

  // Timeout table widened so that every source's field lies inside it.
  localparam int unsigned SpanBits    = (1 << SrcBits) * TimeoutBits;
  localparam int unsigned ToutExtBits =
      (TimeoutTableBits > SpanBits) ? TimeoutTableBits : SpanBits;
  localparam int unsigned OffBits     = $clog2(ToutExtBits);

  logic [PrioTableBits-1:0]    prio_tab_q;
  logic [ModeTableBits-1:0]    mode_tab_q;
  logic [EmergBits-1:0]        emerg_q;
  logic [TimeoutTableBits-1:0] tout_tab_q;

  logic [ModeBits-1:0]    key_mode_q, key_mode_d;
  logic                   owner_valid_q, owner_valid_d;
  logic [SrcBits-1:0]     owner_idx_q, owner_idx_d;
  logic [TimeoutBits-1:0] ticks_q, ticks_d;

  logic                   advance;
  logic                   emit;
  logic [SrcBits-1:0]     src;
  logic                   in_range;
  logic [PrioBits-1:0]    src_prio;
  logic [PrioBits-1:0]    owner_prio;
  logic [ModeBits-1:0]    src_mode;
  logic                   src_emerg;
  logic [ToutExtBits-1:0] tout_ext;
  logic [OffBits-1:0]     tout_off;
  logic [TimeoutBits-1:0] tout_raw;
  logic [TimeoutBits-1:0] tout_reload;
  logic                   take_over;

  // A request is decided in the cycle that its result can be registered.
  assign req_ready_o = res_ready_i;
  assign advance     = req_valid_i && res_ready_i;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_tab_q <= '0;
      mode_tab_q <= '0;
      emerg_q    <= '0;
      tout_tab_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PRIO:    prio_tab_q <= cfg_wdata_i[PrioTableBits-1:0];
        CFG_MODE:    mode_tab_q <= cfg_wdata_i[ModeTableBits-1:0];
        CFG_EMERG:   emerg_q    <= cfg_wdata_i[EmergBits-1:0];
        CFG_TIMEOUT: tout_tab_q <= cfg_wdata_i[TimeoutTableBits-1:0];
      endcase
    end
  end

  // Per-source settings of the requesting source and of the owner.
  assign src        = req_i.source_index;
  assign in_range   = (32'(src) < NumSources);
  assign src_prio   = prio_tab_q[{src, 3'b000} +: PrioBits];
  assign owner_prio = prio_tab_q[{owner_idx_q, 3'b000} +: PrioBits];
  assign src_mode   = mode_tab_q[{src, 2'b00} +: ModeBits];
  assign src_emerg  = emerg_q[src];

  // Timeout reload value; a zero count counts as one tick.
  assign tout_ext    = ToutExtBits'(tout_tab_q);
  assign tout_off    = OffBits'(src) * OffBits'(TimeoutBits);
  assign tout_raw    = tout_ext[tout_off +: TimeoutBits];
  assign tout_reload = (tout_raw == '0) ? TimeoutBits'(1) : tout_raw;

  // An in-range emergency source always wins; otherwise the mode must match and,
  // with an owner present, the priority must be at least the owner's.
  assign take_over = in_range &&
                     (src_emerg ||
                      ((src_mode == key_mode_q) &&
                       (!owner_valid_q || (src_prio >= owner_prio))));

  // Decision and next state.
  always_comb begin
    key_mode_d    = key_mode_q;
    owner_valid_d = owner_valid_q;
    owner_idx_d   = owner_idx_q;
    ticks_d       = ticks_q;
    emit          = 1'b0;
    res_o         = '0;
    unique case (req_i.req_type)
      REQ_CMD: begin
        if (take_over) begin
          owner_valid_d = 1'b1;
          owner_idx_d   = src;
          ticks_d       = tout_reload;
          emit          = 1'b1;
          res_o.twist   = req_i.twist;
          res_o.source  = src;
        end
      end
      REQ_MODE: begin
        if (req_i.new_key_mode != key_mode_q) begin
          key_mode_d    = req_i.new_key_mode;
          owner_valid_d = 1'b0;
          owner_idx_d   = '0;
          ticks_d       = '0;
          emit          = 1'b1;
          res_o.stop    = 1'b1;
        end
      end
      REQ_TICK: begin
        if (ticks_q != '0) begin
          ticks_d = ticks_q - TimeoutBits'(1);
          if (ticks_q == TimeoutBits'(1)) begin
            owner_valid_d = 1'b0;
            owner_idx_d   = '0;
            emit          = 1'b1;
            res_o.stop    = 1'b1;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // State update once the request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_mode_q    <= '0;
      owner_valid_q <= 1'b0;
      owner_idx_q   <= '0;
      ticks_q       <= '0;
    end else if (advance) begin
      key_mode_q    <= key_mode_d;
      owner_valid_q <= owner_valid_d;
      owner_idx_q   <= owner_idx_d;
      ticks_q       <= ticks_d;
    end
  end

  assign res_valid_o            = advance && emit;
  assign status_o.owner_valid   = owner_valid_q;
  assign status_o.timer_running = (ticks_q != '0);

endmodule

FILE: hw/rtl/priority_command_mux_with_timeout_top.sv
// Priority command multiplexer with timeout. Requests (velocity commands,
// key mode switches and time ticks) enter on cmd_i and results leave on res_o.
// The block takes one request every cycle; a request passes an input register
// and the decision logic and lands in the result register, which offers its
// result. A full result register that is not taken holds back the request behind
// it, and only then does cmd_i.ready drop. The four configuration registers
// (priorities, key modes, emergency mask, timeouts) are written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i while idle, which the block leaves to the user.
// Depends on cmx_pkg, the channel interfaces, cmx_pipe_reg and cmx_core.
`include "priority_command_mux_with_timeout_top_defines.svh"

module priority_command_mux_with_timeout_top
  import cmx_pkg::*;
#(
  parameter int unsigned NumSources  = NumSourcesDef,
  parameter int unsigned TimeoutBits = TimeoutBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  cmx_cmd_if.sink                cmd_i,
  cmx_res_if.source              res_o
);

  cmx_req_t    req_in;
  cmx_req_t    req_q;
  logic        req_q_valid;
  logic        core_ready;
  logic        core_res_valid;
  cmx_res_t    core_res;
  logic        out_ready;
  cmx_res_t    res_q;
  cmx_status_t status;

  // Gather the request fields into one word.
  assign req_in.req_type     = cmd_i.req_type;
  assign req_in.source_index = cmd_i.source_index;
  assign req_in.new_key_mode = cmd_i.new_key_mode;
  assign req_in.twist[0]     = cmd_i.linear_x;
  assign req_in.twist[1]     = cmd_i.linear_y;
  assign req_in.twist[2]     = cmd_i.linear_z;
  assign req_in.twist[3]     = cmd_i.angular_x;
  assign req_in.twist[4]     = cmd_i.angular_y;
  assign req_in.twist[5]     = cmd_i.angular_z;

  // Input register.
  cmx_pipe_reg #(
    .Width ($bits(cmx_req_t))
  ) u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cmd_i.valid),
    .data_i  (req_in),
    .ready_o (cmd_i.ready),
    .valid_o (req_q_valid),
    .data_o  (req_q),
    .ready_i (core_ready)
  );

  // Decision logic and state.
  cmx_core #(
    .NumSources  (NumSources),
    .TimeoutBits (TimeoutBits)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (req_q_valid),
    .req_i       (req_q),
    .req_ready_o (core_ready),
    .res_valid_o (core_res_valid),
    .res_o       (core_res),
    .res_ready_i (out_ready),
    .status_o    (status)
  );

  // Result register.
  cmx_pipe_reg #(
    .Width ($bits(cmx_res_t))
  ) u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (core_res_valid),
    .data_i  (core_res),
    .ready_o (out_ready),
    .valid_o (res_o.valid),
    .data_o  (res_q),
    .ready_i (res_o.ready)
  );

  // Spread the result onto the output channel.
  assign res_o.out_linear_x  = res_q.twist[0];
  assign res_o.out_linear_y  = res_q.twist[1];
  assign res_o.out_linear_z  = res_q.twist[2];
  assign res_o.out_angular_x = res_q.twist[3];
  assign res_o.out_angular_y = res_q.twist[4];
  assign res_o.out_angular_z = res_q.twist[5];
  assign res_o.out_source    = res_q.source;
  assign res_o.stop_flag     = res_q.stop;

  // An owner exists exactly while its countdown runs.
  `CMX_ASSERT_IMPLIES(a_owner_timer, clk_i, rst_ni, 1'b1,
                      status.owner_valid == status.timer_running)
  // A forwarded command leaves its source as owner.
  `CMX_ASSERT_NEXT(a_fwd_owner, clk_i, rst_ni, core_res_valid && !core_res.stop,
                   status.owner_valid)
  // A stop leaves no owner behind.
  `CMX_ASSERT_NEXT(a_stop_clear, clk_i, rst_ni, core_res_valid && core_res.stop,
                   !status.owner_valid)
  // A stop offered at the output carries zero words and source zero.
  `CMX_ASSERT_IMPLIES(a_stop_zero, clk_i, rst_ni, res_o.valid && res_o.stop_flag,
                      res_q.twist == '0 && res_q.source == '0)

endmodule

FILE: dv/priority_command_mux_with_timeout_top_tb.sv
// Self-checking testbench for the priority command multiplexer with timeout.
// Depends on cmx_pkg, the channel interfaces in cmx_if.sv and the top level;
// it predicts every result and checks each one as it leaves the block.
module priority_command_mux_with_timeout_top_tb;
  import cmx_pkg::*;

  localparam logic [ReqTypeBits-1:0] ReqUnused = 2'd3;
  localparam int TimeoutBits   = TimeoutBitsDef;
  localparam int DrainCycles   = 4;
  localparam int StallLimit    = 2000;
  localparam int HoldOffCycles = 300;
  localparam int NumPhases     = 8;
  localparam int PhaseRequests = 200;
  localparam int MaxReports    = 10;

  // How the expected result of a directed row is obtained.
  typedef enum logic [1:0] {
    FORM_PREDICT,
    FORM_NONE,
    FORM_STOP,
    FORM_FORWARD
  } exp_form_e;

  typedef enum logic {
    ROW_REQUEST,
    ROW_SETTINGS
  } row_kind_e;

  // One row of the directed table: either a request or a new set of registers.
  typedef struct packed {
    row_kind_e                kind;
    exp_form_e                form;
    logic [ReqTypeBits-1:0]   rtype;
    logic [SrcBits-1:0]       src;
    logic [ModeBits-1:0]      key;
    logic                     rand_words;
    word_t                    fill;
    logic [PrioTableBits-1:0] prio;
    logic [ModeTableBits-1:0] modes;
    logic [EmergBits-1:0]     emerg;
    logic [TimeoutTableBits-1:0] tmo;
  } plan_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_wdata_i;

  cmx_cmd_if cmd_bus ();
  cmx_res_if res_bus ();

  priority_command_mux_with_timeout_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_bus),
    .res_o       (res_bus)
  );

  // Predictor copy of the configuration and of the ownership state.
  logic [PrioTableBits-1:0]    prio_table    = '0;
  logic [ModeTableBits-1:0]    mode_table    = '0;
  logic [EmergBits-1:0]        emerg_mask    = '0;
  logic [TimeoutTableBits-1:0] timeout_table = '0;
  logic [ModeBits-1:0]         mux_key_mode    = '0;
  logic                        mux_owner_valid = 1'b0;
  logic [SrcBits-1:0]          mux_owner       = '0;
  logic [TimeoutBits-1:0]      mux_ticks       = '0;

  cmx_res_t  owed_outputs [$];
  int        fault_count      = 0;
  bit        steady_sender    = 1'b0;
  bit        steady_sink      = 1'b0;
  int        sink_hold_cycles = 0;
  plan_row_t directed_plan [$];

  // Clock: period of 10.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Appends one expected output to the tail of the queue.
  function automatic void owe_output(input cmx_res_t res);
    owed_outputs = {owed_outputs, res};
  endfunction

  // Appends one row to the directed table.
  function automatic void plan_add(input plan_row_t row);
    directed_plan = {directed_plan, row};
  endfunction

  // Works out the output that one request causes and advances the state.
  function automatic bit arbitrate_request(input cmx_req_t r, output cmx_res_t res);
    logic [SrcBits-1:0]     s;
    logic                   em;
    logic [ModeBits-1:0]    m;
    logic [TimeoutBits-1:0] tmo;
    res = '0;
    case (r.req_type)
      REQ_CMD: begin
        s  = r.source_index;
        em = emerg_mask[s];
        m  = mode_table[s*ModeBits +: ModeBits];
        // With no owner, a matching or emergency source claims ownership first.
        if (!mux_owner_valid) begin
          if (m != mux_key_mode && !em) return 1'b0;
          mux_owner_valid = 1'b1;
          mux_owner       = s;
        end
        if (!em && m != mux_key_mode) return 1'b0;
        if (!em && prio_table[s*PrioBits +: PrioBits] < prio_table[mux_owner*PrioBits +: PrioBits])
          return 1'b0;
        tmo             = timeout_table[s*TimeoutBits +: TimeoutBits];
        mux_owner       = s;
        mux_owner_valid = 1'b1;
        mux_ticks       = (tmo == '0) ? TimeoutBits'(1) : tmo;
        res.twist       = r.twist;
        res.source      = s;
        return 1'b1;
      end
      REQ_MODE: begin
        if (r.new_key_mode == mux_key_mode) return 1'b0;
        mux_key_mode    = r.new_key_mode;
        mux_owner_valid = 1'b0;
        mux_owner       = '0;
        mux_ticks       = '0;
        res.stop        = 1'b1;
        return 1'b1;
      end
      REQ_TICK: begin
        // A stopped timer ignores ticks; reaching zero releases the owner.
        if (mux_ticks == '0) return 1'b0;
        mux_ticks = mux_ticks - 1'b1;
        if (mux_ticks != '0) return 1'b0;
        mux_owner_valid = 1'b0;
        mux_owner       = '0;
        res.stop        = 1'b1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int draw_gap(input bit steady);
    return steady ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic plan_row_t ask(input logic [ReqTypeBits-1:0] rtype,
                                    input logic [SrcBits-1:0] src,
                                    input logic [ModeBits-1:0] key,
                                    input exp_form_e form,
                                    input logic rand_words,
                                    input word_t fill);
    plan_row_t row;
    row            = '0;
    row.kind       = ROW_REQUEST;
    row.form       = form;
    row.rtype      = rtype;
    row.src        = src;
    row.key        = key;
    row.rand_words = rand_words;
    row.fill       = fill;
    return row;
  endfunction

  function automatic plan_row_t settle(input logic [PrioTableBits-1:0] prio,
                                       input logic [ModeTableBits-1:0] modes,
                                       input logic [EmergBits-1:0] emerg,
                                       input logic [TimeoutTableBits-1:0] tmo);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_SETTINGS;
    row.prio  = prio;
    row.modes = modes;
    row.emerg = emerg;
    row.tmo   = tmo;
    return row;
  endfunction

  // Random request: mostly commands and ticks, mode switches mostly to modes in use.
  function automatic cmx_req_t draw_request();
    cmx_req_t r;
    int       pick;
    pick           = $urandom_range(0, 99);
    r.source_index = SrcBits'($urandom_range(0, 3));
    r.new_key_mode = ModeBits'($urandom_range(0, 15));
    for (int i = 0; i < NumWords; i++) r.twist[i] = $urandom;
    if (pick < 50) begin
      r.req_type = REQ_CMD;
    end else if (pick < 78) begin
      r.req_type = REQ_TICK;
    end else if (pick < 95) begin
      r.req_type = REQ_MODE;
      if ($urandom_range(0, 3) != 0)
        r.new_key_mode = mode_table[ModeBits*$urandom_range(0, 3) +: ModeBits];
    end else begin
      r.req_type = ReqUnused;
    end
    return r;
  endfunction

  // Offers one request and records its expected output once it is accepted.
  task automatic push_request(input cmx_req_t r, input exp_form_e form);
    int       gap;
    cmx_res_t predicted;
    cmx_res_t typed;
    bit       has_output;
    gap = draw_gap(steady_sender);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.req_type     <= r.req_type;
    cmd_bus.source_index <= r.source_index;
    cmd_bus.new_key_mode <= r.new_key_mode;
    cmd_bus.linear_x     <= r.twist[0];
    cmd_bus.linear_y     <= r.twist[1];
    cmd_bus.linear_z     <= r.twist[2];
    cmd_bus.angular_x    <= r.twist[3];
    cmd_bus.angular_y    <= r.twist[4];
    cmd_bus.angular_z    <= r.twist[5];
    cmd_bus.valid        <= 1'b1;
    do @(posedge clk_i); while (!cmd_bus.ready);
    has_output = arbitrate_request(r, predicted);
    typed      = '0;
    case (form)
      FORM_PREDICT: if (has_output) owe_output(predicted);
      FORM_STOP: begin
        typed.stop = 1'b1;
        owe_output(typed);
      end
      FORM_FORWARD: begin
        typed.twist  = r.twist;
        typed.source = r.source_index;
        owe_output(typed);
      end
      default: ;
    endcase
  endtask

  // Waits until every owed output has left, then lets the pipeline empty.
  task automatic settle_block();
    cmd_bus.valid <= 1'b0;
    while (owed_outputs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes all four registers back to back while the block is idle.
  task automatic apply_settings(input logic [PrioTableBits-1:0] prio,
                                input logic [ModeTableBits-1:0] modes,
                                input logic [EmergBits-1:0] emerg,
                                input logic [TimeoutTableBits-1:0] tmo);
    logic [CfgDataBits-1:0] values [4];
    values[CFG_PRIO]    = CfgDataBits'(prio);
    values[CFG_MODE]    = CfgDataBits'(modes);
    values[CFG_EMERG]   = CfgDataBits'(emerg);
    values[CFG_TIMEOUT] = CfgDataBits'(tmo);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_idx_e'(i);
      cfg_wdata_i <= values[i];
      @(posedge clk_i);
    end
    cfg_we_i      <= 1'b0;
    prio_table    = prio;
    mode_table    = modes;
    emerg_mask    = emerg;
    timeout_table = tmo;
  endtask

  // Compares one output with the oldest owed one, field by field.
  task automatic check_output(input cmx_res_t got);
    cmx_res_t exp;
    bit       bad;
    if (owed_outputs.size() == 0) begin
      fault_count++;
      if (fault_count <= MaxReports)
        $display("unexpected output: words %h source %0d stop %0d",
                 got.twist, got.source, got.stop);
    end else begin
      exp = owed_outputs.pop_front();
      bad = 1'b0;
      for (int i = 0; i < NumWords; i++) if (got.twist[i] !== exp.twist[i]) bad = 1'b1;
      if (got.source !== exp.source) bad = 1'b1;
      if (got.stop !== exp.stop) bad = 1'b1;
      if (bad) begin
        fault_count++;
        if (fault_count <= MaxReports)
          $display({"output mismatch: expected words %h source %0d stop %0d, ",
                    "got words %h source %0d stop %0d"},
                   exp.twist, exp.source, exp.stop, got.twist, got.source, got.stop);
      end
    end
  endtask

  // Output side: random stalls, plus one long hold-off when asked for.
  initial begin : output_sink
    int       gap;
    cmx_res_t got;
    res_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (sink_hold_cycles > 0) begin
        gap              = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        gap = draw_gap(steady_sink);
      end
      if (gap > 0) begin
        res_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!res_bus.valid);
      got.twist[0] = res_bus.out_linear_x;
      got.twist[1] = res_bus.out_linear_y;
      got.twist[2] = res_bus.out_linear_z;
      got.twist[3] = res_bus.out_angular_x;
      got.twist[4] = res_bus.out_angular_y;
      got.twist[5] = res_bus.out_angular_z;
      got.source   = res_bus.out_source;
      got.stop     = res_bus.stop_flag;
      check_output(got);
    end
  end

  // Watchdog: ends the run when no request or output moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("priority_command_mux_with_timeout_top test failed");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin : stimulus
    cmx_req_t r;
    int       sent;
    logic [TimeoutTableBits-1:0] tmo;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CFG_PRIO;
    cfg_wdata_i          <= '0;
    cmd_bus.valid        <= 1'b0;
    cmd_bus.req_type     <= REQ_CMD;
    cmd_bus.source_index <= '0;
    cmd_bus.new_key_mode <= '0;
    cmd_bus.linear_x     <= '0;
    cmd_bus.linear_y     <= '0;
    cmd_bus.linear_z     <= '0;
    cmd_bus.angular_x    <= '0;
    cmd_bus.angular_y    <= '0;
    cmd_bus.angular_z    <= '0;

    // Directed table; the first rows run on the reset configuration.
    plan_add(ask(ReqUnused, 2'd0, 4'd0,  FORM_NONE,    1'b0, '1));
    plan_add(ask(REQ_TICK,  2'd0, 4'd0,  FORM_NONE,    1'b0, '0));
    plan_add(ask(REQ_MODE,  2'd0, 4'd0,  FORM_NONE,    1'b0, '0));
    plan_add(ask(REQ_CMD,   2'd0, 4'd0,  FORM_FORWARD, 1'b0, '1));
    plan_add(ask(REQ_TICK,  2'd0, 4'd0,  FORM_STOP,    1'b0, '0));
    plan_add(ask(REQ_CMD,   2'd3, 4'd0,  FORM_FORWARD, 1'b0, '0));
    plan_add(ask(REQ_MODE,  2'd0, 4'd15, FORM_STOP,    1'b0, '0));
    plan_add(ask(REQ_CMD,   2'd1, 4'd0,  FORM_NONE,    1'b0, '1));
    plan_add(ask(REQ_TICK,  2'd0, 4'd0,  FORM_NONE,    1'b0, '0));
    plan_add(ask(REQ_MODE,  2'd0, 4'd0,  FORM_STOP,    1'b0, '0));
    // Mixed priorities, source 3 emergency with a long timeout, source 1 zero timeout.
    plan_add(settle(32'hFF00_4010, 16'hF555, 4'b1000, 48'hFFF_001_000_003));
    plan_add(ask(REQ_MODE,  2'd0, 4'd5,  FORM_STOP,    1'b0, '0));
    plan_add(ask(REQ_CMD,   2'd1, 4'd0,  FORM_PREDICT, 1'b1, '0));
    plan_add(ask(REQ_CMD,   2'd0, 4'd0,  FORM_PREDICT, 1'b1, '0));
    plan_add(ask(REQ_CMD,   2'd2, 4'd0,  FORM_PREDICT, 1'b1, '0));
    plan_add(ask(REQ_CMD,   2'd3, 4'd0,  FORM_PREDICT, 1'b1, '0));
    plan_add(ask(REQ_CMD,   2'd1, 4'd0,  FORM_PREDICT, 1'b1, '0));
    plan_add(ask(REQ_TICK,  2'd0, 4'd0,  FORM_PREDICT, 1'b0, '0));
    plan_add(ask(REQ_MODE,  2'd0, 4'd15, FORM_PREDICT, 1'b0, '0));
    plan_add(ask(REQ_CMD,   2'd3, 4'd0,  FORM_PREDICT, 1'b1, '0));
    plan_add(ask(REQ_MODE,  2'd0, 4'd5,  FORM_PREDICT, 1'b0, '0));
    plan_add(ask(REQ_CMD,   2'd0, 4'd0,  FORM_PREDICT, 1'b1, '0));
    plan_add(ask(REQ_TICK,  2'd0, 4'd0,  FORM_PREDICT, 1'b0, '0));
    plan_add(ask(REQ_TICK,  2'd0, 4'd0,  FORM_PREDICT, 1'b0, '0));
    plan_add(ask(REQ_TICK,  2'd0, 4'd0,  FORM_PREDICT, 1'b0, '0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_SETTINGS) begin
        settle_block();
        apply_settings(directed_plan[i].prio, directed_plan[i].modes,
                       directed_plan[i].emerg, directed_plan[i].tmo);
      end else begin
        r.req_type     = directed_plan[i].rtype;
        r.source_index = directed_plan[i].src;
        r.new_key_mode = directed_plan[i].key;
        for (int w = 0; w < NumWords; w++)
          r.twist[w] = directed_plan[i].rand_words ? word_t'($urandom) : directed_plan[i].fill;
        push_request(r, directed_plan[i].form);
      end
    end

    // Random phases: all-zero and all-one registers first, then random settings.
    for (int phase = 0; phase < NumPhases; phase++) begin
      settle_block();
      steady_sender = (phase == 2) || (phase == 3);
      steady_sink   = (phase == 3);
      if (phase == 0) begin
        apply_settings('0, '0, '0, '0);
      end else if (phase == 1) begin
        apply_settings('1, '1, '1, '1);
      end else begin
        for (int s = 0; s < 4; s++)
          tmo[s*TimeoutBits +: TimeoutBits] = TimeoutBits'($urandom_range(0, 5));
        apply_settings($urandom,
                       {4'($urandom_range(0, 3)), 4'($urandom_range(0, 3)),
                        4'($urandom_range(0, 3)), 4'($urandom_range(0, 3))},
                       EmergBits'($urandom_range(0, 15)), tmo);
      end
      // Hold the output side off while requests keep coming, so the block backs up.
      if (phase == 2) sink_hold_cycles = HoldOffCycles;
      sent = 0;
      while (sent < PhaseRequests) begin
        r = draw_request();
        push_request(r, FORM_PREDICT);
        if (r.req_type != ReqUnused) sent++;
      end
    end

    settle_block();
    if (fault_count == 0 && owed_outputs.size() == 0) begin
      $display("priority_command_mux_with_timeout_top test passed");
    end else begin
      $display("priority_command_mux_with_timeout_top test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/cmx_pkg.sv
hw/rtl/cmx_if.sv
hw/rtl/cmx_pipe_reg.sv
hw/rtl/cmx_core.sv
hw/rtl/priority_command_mux_with_timeout_top.sv
dv/priority_command_mux_with_timeout_top_tb.sv
